// File: hdl/superio_index_data_config_space_core_assert.svh
// assertion helpers for the config space datapath
`ifndef SUPERIO_INDEX_DATA_CONFIG_SPACE_CORE_ASSERT_SVH
`define SUPERIO_INDEX_DATA_CONFIG_SPACE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SIOCFG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SIOCFG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/siocfg_pkg.sv
package siocfg_pkg;

    // bus access codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_READ   = 1'b1;
    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    // result kinds
    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // index port keys
    localparam logic [7:0] KEY_ENTER = 8'h55;
    localparam logic [7:0] KEY_LEAVE = 8'hAA;

    // register map
    localparam logic [7:0] GLOBAL_LIMIT = 8'h30;
    localparam logic [7:0] REG_DEV_SEL  = 8'h07;
    localparam logic [7:0] REG_PORT_LO  = 8'h26;
    localparam logic [7:0] REG_PORT_HI  = 8'h27;
    localparam logic [7:0] REG_ACTIVATE = 8'h30;
    localparam logic [7:0] REG_BASE_HI  = 8'h60;
    localparam logic [7:0] REG_BASE_LO  = 8'h61;
    localparam logic [7:0] REG_IRQ      = 8'h70;

    // logical devices of the two serial ports
    localparam logic [7:0] SERIAL0_DEV = 8'h04;
    localparam logic [7:0] SERIAL1_DEV = 8'h05;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic load_rd;
        logic load_rpt;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic acc_read;
        logic leave_rpt;
        logic out_free;
        logic rpt_one;
    } t_dp_stat;

endpackage

// File: hdl/siocfg_ctrl.sv
module siocfg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  siocfg_pkg::t_dp_stat i_stat,
    output siocfg_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_RPT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.clr_step = (r_state == S_CLEAR);
    assign o_cmd.accept   = o_in_ready && i_in_valid;
    assign o_cmd.load_rd  = (r_state == S_READ) && i_stat.out_free;
    assign o_cmd.load_rpt = (r_state == S_RPT) && i_stat.out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_cmd.accept) begin
                    if (i_stat.acc_read) begin
                        n_state = S_READ;
                    end else if (i_stat.leave_rpt) begin
                        n_state = S_RPT;
                    end
                end
            end
            S_READ: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RPT: begin
                if (i_stat.out_free && i_stat.rpt_one) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/siocfg_dp.sv
`include "superio_index_data_config_space_core_assert.svh"

module siocfg_dp #(
    parameter int NUM_DEVICES      = 12,
    parameter int GLOBAL_REG_COUNT = 48,
    parameter int DEVICE_REG_COUNT = 256,
    parameter int CONFIG_PORT_BASE = 46
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  siocfg_pkg::t_dp_cmd  i_cmd,
    output siocfg_pkg::t_dp_stat o_stat,
    input  logic                 i_action,
    input  logic                 i_port_sel,
    input  logic [7:0]           i_write_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_kind,
    output logic [7:0]           o_read_byte,
    output logic                 o_serial_unit,
    output logic [15:0]          o_io_base,
    output logic [7:0]           o_irq_line,
    output logic                 o_last
);

    localparam int GAW       = $clog2(GLOBAL_REG_COUNT);
    localparam int IDX_W     = $clog2(DEVICE_REG_COUNT);
    localparam int DEV_W     = $clog2(NUM_DEVICES);
    localparam int DAW       = DEV_W + IDX_W;
    localparam int DEV_DEPTH = NUM_DEVICES << IDX_W;

    localparam logic [8:0]     GRC_L     = 9'(GLOBAL_REG_COUNT);
    localparam logic [8:0]     DRC_L     = 9'(DEVICE_REG_COUNT);
    localparam logic [7:0]     NDEV_L    = 8'(NUM_DEVICES);
    localparam logic [DAW-1:0] CLR_GLB   = DAW'(GLOBAL_REG_COUNT);
    localparam logic [DAW-1:0] CLR_LAST  = DAW'(DEV_DEPTH - 1);
    localparam logic [15:0]    PORT_BASE = 16'(CONFIG_PORT_BASE);

    logic [7:0] r_gmem [GLOBAL_REG_COUNT];
    logic [7:0] r_dmem [DEV_DEPTH];

    // control state
    logic           r_config_mode;
    logic [7:0]     r_sel_idx;
    logic [7:0]     r_dev_sel;
    logic [1:0]     r_active;
    logic [1:0]     r_pend;
    logic [DAW-1:0] r_clr_cnt;
    logic           r_out_valid;
    logic           r_rd_glb;
    logic           r_rd_dev;

    // copies of the serial port registers
    logic [1:0] r_act_nz;
    logic [7:0] r_base_hi [2];
    logic [7:0] r_base_lo [2];
    logic [7:0] r_irq     [2];

    // payload
    logic [7:0]  r_g_rdata;
    logic [7:0]  r_d_rdata;
    logic        r_kind;
    logic [7:0]  r_read_byte;
    logic        r_unit;
    logic [15:0] r_io_base;
    logic [7:0]  r_irq_line;
    logic        r_last;

    logic           glb_hit;
    logic           dev_hit;
    logic [GAW-1:0] gaddr;
    logic [DAW-1:0] daddr;
    logic           idx_wr;
    logic           data_wr;
    logic           data_rd;
    logic           enter_wr;
    logic           leave_wr;
    logic           sel_wr;
    logic [1:0]     pend_c;
    logic           ser_wr;
    logic           ser_u;
    logic           clr_glb;
    logic [7:0]     clr_gval;
    logic           rpt_u;
    logic [7:0]     rd_val;

    assign glb_hit = (r_sel_idx < siocfg_pkg::GLOBAL_LIMIT) && ({1'b0, r_sel_idx} < GRC_L);
    assign dev_hit = (r_sel_idx >= siocfg_pkg::GLOBAL_LIMIT) && (r_dev_sel < NDEV_L)
                     && ({1'b0, r_sel_idx} < DRC_L);
    assign gaddr   = r_sel_idx[GAW-1:0];
    assign daddr   = {r_dev_sel[DEV_W-1:0], r_sel_idx[IDX_W-1:0]};

    assign idx_wr   = i_cmd.accept && (i_action == siocfg_pkg::ACT_WRITE)
                      && (i_port_sel == siocfg_pkg::PORT_INDEX);
    assign data_wr  = i_cmd.accept && (i_action == siocfg_pkg::ACT_WRITE)
                      && (i_port_sel == siocfg_pkg::PORT_DATA);
    assign data_rd  = i_cmd.accept && (i_action == siocfg_pkg::ACT_READ)
                      && (i_port_sel == siocfg_pkg::PORT_DATA);
    assign enter_wr = idx_wr && (i_write_byte == siocfg_pkg::KEY_ENTER);
    assign leave_wr = idx_wr && (i_write_byte == siocfg_pkg::KEY_LEAVE);
    assign sel_wr   = idx_wr && !enter_wr && !leave_wr;

    assign pend_c = r_act_nz & ~r_active;

    assign ser_wr = data_wr && dev_hit && ((r_dev_sel == siocfg_pkg::SERIAL0_DEV)
                    || (r_dev_sel == siocfg_pkg::SERIAL1_DEV));
    assign ser_u  = (r_dev_sel == siocfg_pkg::SERIAL1_DEV);

    assign clr_glb  = i_cmd.clr_step && (r_clr_cnt < CLR_GLB);
    assign clr_gval = (r_clr_cnt == DAW'(siocfg_pkg::REG_PORT_LO)) ? PORT_BASE[7:0]  :
                      (r_clr_cnt == DAW'(siocfg_pkg::REG_PORT_HI)) ? PORT_BASE[15:8] :
                      8'h00;

    // unit 0 goes out first
    assign rpt_u  = !r_pend[0];
    assign rd_val = r_rd_glb ? r_g_rdata : (r_rd_dev ? r_d_rdata : 8'h00);

    assign o_stat.clr_last  = (r_clr_cnt == CLR_LAST);
    assign o_stat.acc_read  = (i_action == siocfg_pkg::ACT_READ);
    assign o_stat.leave_rpt = (i_port_sel == siocfg_pkg::PORT_INDEX)
                              && (i_write_byte == siocfg_pkg::KEY_LEAVE) && (pend_c != 2'b00);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.rpt_one   = r_pend[0] ^ r_pend[1];

    always_ff @(posedge i_clk) begin
        if (clr_glb) begin
            r_gmem[r_clr_cnt[GAW-1:0]] <= clr_gval;
        end else if (data_wr && glb_hit) begin
            r_gmem[gaddr] <= i_write_byte;
        end
        if (data_rd && glb_hit) begin
            r_g_rdata <= r_gmem[gaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_dmem[r_clr_cnt] <= 8'h00;
        end else if (data_wr && dev_hit) begin
            r_dmem[daddr] <= i_write_byte;
        end
        if (data_rd && dev_hit) begin
            r_d_rdata <= r_dmem[daddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_config_mode <= 1'b0;
            r_sel_idx     <= 8'h00;
            r_dev_sel     <= 8'h00;
            r_active      <= 2'b00;
            r_pend        <= 2'b00;
            r_clr_cnt     <= '0;
            r_out_valid   <= 1'b0;
            r_rd_glb      <= 1'b0;
            r_rd_dev      <= 1'b0;
            r_act_nz      <= 2'b00;
            r_base_hi     <= '{default: 8'h00};
            r_base_lo     <= '{default: 8'h00};
            r_irq         <= '{default: 8'h00};
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (enter_wr) begin
                r_config_mode <= 1'b1;
            end
            if (leave_wr) begin
                r_config_mode <= 1'b0;
                r_active      <= r_active | pend_c;
                r_pend        <= pend_c;
            end else if (i_cmd.load_rpt) begin
                if (r_pend[0]) begin
                    r_pend[0] <= 1'b0;
                end else begin
                    r_pend[1] <= 1'b0;
                end
            end
            if (sel_wr) begin
                r_sel_idx <= i_write_byte;
            end
            if (data_wr && glb_hit && (r_sel_idx == siocfg_pkg::REG_DEV_SEL)) begin
                r_dev_sel <= i_write_byte;
            end
            if (ser_wr) begin
                case (r_sel_idx)
                    siocfg_pkg::REG_ACTIVATE: r_act_nz[ser_u]  <= (i_write_byte != 8'h00);
                    siocfg_pkg::REG_BASE_HI:  r_base_hi[ser_u] <= i_write_byte;
                    siocfg_pkg::REG_BASE_LO:  r_base_lo[ser_u] <= i_write_byte;
                    siocfg_pkg::REG_IRQ:      r_irq[ser_u]     <= i_write_byte;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_rd_glb <= (i_port_sel == siocfg_pkg::PORT_DATA) && glb_hit;
                r_rd_dev <= (i_port_sel == siocfg_pkg::PORT_DATA) && dev_hit;
            end
            if (i_cmd.load_rd || i_cmd.load_rpt) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rd) begin
            r_kind      <= siocfg_pkg::KIND_READ;
            r_read_byte <= rd_val;
            r_unit      <= 1'b0;
            r_io_base   <= 16'h0000;
            r_irq_line  <= 8'h00;
            r_last      <= 1'b1;
        end else if (i_cmd.load_rpt) begin
            r_kind      <= siocfg_pkg::KIND_REPORT;
            r_read_byte <= 8'h00;
            r_unit      <= rpt_u;
            r_io_base   <= {r_base_hi[rpt_u], r_base_lo[rpt_u]};
            r_irq_line  <= r_irq[rpt_u];
            r_last      <= r_pend[0] ^ r_pend[1];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_read_byte   = r_read_byte;
    assign o_serial_unit = r_unit;
    assign o_io_base     = r_io_base;
    assign o_irq_line    = r_irq_line;
    assign o_last        = r_last;

    `SIOCFG_ASSERT_NEXT(a_enter_sets_mode, enter_wr, r_config_mode, "enter key did not set mode")
    `SIOCFG_ASSERT_NEXT(a_leave_clears_mode, leave_wr, !r_config_mode, "leave key kept mode")
    `SIOCFG_ASSERT_NOW(a_rpt_has_pend, i_cmd.load_rpt, r_pend != 2'b00, "report with none pending")
    `SIOCFG_ASSERT_NOW(a_one_load, i_cmd.load_rd || i_cmd.load_rpt,
        !i_cmd.accept && !(i_cmd.load_rd && i_cmd.load_rpt), "load overlaps another command")

endmodule

// File: hdl/superio_index_data_config_space_core.sv
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------------------
// access   | in        | i_in_valid / o_in_ready    | i_action, i_port_sel, i_write_byte
// result   | out       | o_out_valid / i_out_ready  | o_kind, o_read_byte, o_serial_unit,
//          |           |                            | o_io_base, o_irq_line, o_last
//
// write access: the register file is written at the transfer edge
// read access: a registered memory read, then the output register is loaded once it is free
// leave key with n activation reports: one report loaded per cycle while the output register is free
// after reset the device register file is swept to zero, all NUM_DEVICES * 2**clog2(DEVICE_REG_COUNT)
//   entries (3072 at the defaults), with o_in_ready low; global registers are set in the same pass
// a stalled result holds in the output register; index and write accesses still transfer,
//   a read or report waits for the output register to free up
module superio_index_data_config_space_core #(
    parameter int NUM_DEVICES      = 12,
    parameter int GLOBAL_REG_COUNT = 48,
    parameter int DEVICE_REG_COUNT = 256,
    parameter int CONFIG_PORT_BASE = 46
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // access channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic        i_port_sel,
    input  logic [7:0]  i_write_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_read_byte,
    output logic        o_serial_unit,
    output logic [15:0] o_io_base,
    output logic [7:0]  o_irq_line,
    output logic        o_last
);

    // commands from the sequencer, status back from the datapath
    siocfg_pkg::t_dp_cmd  cmd;
    siocfg_pkg::t_dp_stat stat;

    // sequencer: clearing pass, idle, read completion, report emission
    siocfg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: index register, global and device register files,
    // serial port register copies and the output register
    siocfg_dp #(
        .NUM_DEVICES      (NUM_DEVICES),
        .GLOBAL_REG_COUNT (GLOBAL_REG_COUNT),
        .DEVICE_REG_COUNT (DEVICE_REG_COUNT),
        .CONFIG_PORT_BASE (CONFIG_PORT_BASE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_action),
        .i_port_sel    (i_port_sel),
        .i_write_byte  (i_write_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_read_byte   (o_read_byte),
        .o_serial_unit (o_serial_unit),
        .o_io_base     (o_io_base),
        .o_irq_line    (o_irq_line),
        .o_last        (o_last)
    );

endmodule

// File: sim/tb_superio_index_data_config_space_core.sv
`timescale 1ns / 1ps

module tb_superio_index_data_config_space_core;

    localparam int NDEV       = 12;
    localparam int GREGS      = 48;
    localparam int DREGS      = 256;
    localparam int PORT_BASE  = 46;
    localparam int N_ITEMS    = 1650;
    localparam int LONG_HOLD  = 150;
    localparam int CYCLE_CAP  = 200000;

    // one result transfer, field for field as the block presents it
    typedef struct packed {
        logic        kind;
        logic [7:0]  read_byte;
        logic        unit;
        logic [15:0] io_base;
        logic [7:0]  irq;
        logic        last;
    } t_result;

    // shadow copy of the config space; every accepted access updates it and
    // queues the results that access must produce
    class t_cfg_space_scoreboard;
        logic [7:0] glob_regs [GREGS];
        logic [7:0] dev_regs [NDEV][DREGS];
        bit         cfg_mode;
        logic [7:0] sel_index;
        bit         uart_live [2];
        t_result    expected_q [$];
        int         errors;
        int         checked;

        function new();
            foreach (glob_regs[i]) glob_regs[i] = 8'h00;
            foreach (dev_regs[d, r]) dev_regs[d][r] = 8'h00;
            if (siocfg_pkg::REG_PORT_LO < GREGS)
                glob_regs[siocfg_pkg::REG_PORT_LO] = PORT_BASE[7:0];
            if (siocfg_pkg::REG_PORT_HI < GREGS)
                glob_regs[siocfg_pkg::REG_PORT_HI] = PORT_BASE[15:8];
            cfg_mode     = 1'b0;
            sel_index    = 8'h00;
            uart_live[0] = 1'b0;
            uart_live[1] = 1'b0;
            errors       = 0;
            checked      = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch on result %0d: %s", $time, checked, msg);
            errors++;
        endtask

        // data port read through the current index and device select
        function logic [7:0] data_port_read();
            int dev;
            dev = glob_regs[siocfg_pkg::REG_DEV_SEL];
            if (sel_index < siocfg_pkg::GLOBAL_LIMIT)
                return (sel_index < GREGS) ? glob_regs[sel_index] : 8'h00;
            if (dev >= NDEV || sel_index >= DREGS)
                return 8'h00;
            return dev_regs[dev][sel_index];
        endfunction

        function void data_port_write(logic [7:0] data);
            int dev;
            dev = glob_regs[siocfg_pkg::REG_DEV_SEL];
            if (sel_index < siocfg_pkg::GLOBAL_LIMIT) begin
                if (sel_index < GREGS)
                    glob_regs[sel_index] = data;
            end else if (dev < NDEV && sel_index < DREGS) begin
                dev_regs[dev][sel_index] = data;
            end
        endfunction

        function void note_access(logic action, logic port, logic [7:0] data);
            t_result r;
            int      u;
            int      n_rpt;
            int      dev;
            r = '0;
            if (action == siocfg_pkg::ACT_READ) begin
                r.kind      = siocfg_pkg::KIND_READ;
                r.read_byte = (port == siocfg_pkg::PORT_DATA) ? data_port_read() : 8'h00;
                r.last      = 1'b1;
                expected_q.push_back(r);
                return;
            end
            if (port == siocfg_pkg::PORT_DATA) begin
                data_port_write(data);
                return;
            end
            if (data == siocfg_pkg::KEY_ENTER) begin
                cfg_mode = 1'b1;
                return;
            end
            if (data != siocfg_pkg::KEY_LEAVE) begin
                sel_index = data;
                return;
            end
            // leave key: every serial port switched on since the last check is reported once
            cfg_mode = 1'b0;
            n_rpt    = 0;
            for (u = 0; u < 2; u++) begin
                dev = (u == 0) ? siocfg_pkg::SERIAL0_DEV : siocfg_pkg::SERIAL1_DEV;
                if (dev_regs[dev][siocfg_pkg::REG_ACTIVATE] != 8'h00 && !uart_live[u]) begin
                    r           = '0;
                    r.kind      = siocfg_pkg::KIND_REPORT;
                    r.unit      = u[0];
                    r.io_base   = {dev_regs[dev][siocfg_pkg::REG_BASE_HI],
                                   dev_regs[dev][siocfg_pkg::REG_BASE_LO]};
                    r.irq       = dev_regs[dev][siocfg_pkg::REG_IRQ];
                    expected_q.push_back(r);
                    uart_live[u] = 1'b1;
                    n_rpt++;
                end
            end
            if (n_rpt > 0)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            checked++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result, kind %0d byte 0x%0h", got.kind,
                                 got.read_byte));
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("read_byte", got.read_byte, want.read_byte);
            compare_field("serial_unit", got.unit, want.unit);
            compare_field("io_base", got.io_base, want.io_base);
            compare_field("irq_line", got.irq, want.irq);
            compare_field("last", got.last, want.last);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        acc_valid;
    logic        acc_ready;
    logic        acc_action;
    logic        acc_port;
    logic [7:0]  acc_byte;
    logic        res_valid;
    logic        res_ready;
    logic        res_kind;
    logic [7:0]  res_byte;
    logic        res_unit;
    logic [15:0] res_base;
    logic [7:0]  res_irq;
    logic        res_last;

    t_cfg_space_scoreboard sb;
    int items_sent   = 0;
    int results_seen = 0;
    int cycles       = 0;

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    superio_index_data_config_space_core #(
        .NUM_DEVICES      (NDEV),
        .GLOBAL_REG_COUNT (GREGS),
        .DEVICE_REG_COUNT (DREGS),
        .CONFIG_PORT_BASE (PORT_BASE)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (acc_valid),
        .o_in_ready    (acc_ready),
        .i_action      (acc_action),
        .i_port_sel    (acc_port),
        .i_write_byte  (acc_byte),
        .o_out_valid   (res_valid),
        .i_out_ready   (res_ready),
        .o_kind        (res_kind),
        .o_read_byte   (res_byte),
        .o_serial_unit (res_unit),
        .o_io_base     (res_base),
        .o_irq_line    (res_irq),
        .o_last        (res_last)
    );

    // hard stop; covers the register sweep after reset and every stall at its worst
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one bus access: random gap, then hold the transfer until the block takes it
    task bus_access(logic action, logic port, logic [7:0] data);
        int gap;
        // every third stretch of 150 accesses goes back to back
        gap = ((items_sent / 150) % 3 == 2) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            acc_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        acc_valid  <= 1'b1;
        acc_action <= action;
        acc_port   <= port;
        acc_byte   <= data;
        @(posedge clk);
        while (!acc_ready) @(posedge clk);
        sb.note_access(action, port, data);
        items_sent++;
    endtask

    task reg_write(logic [7:0] idx, logic [7:0] data);
        bus_access(siocfg_pkg::ACT_WRITE, siocfg_pkg::PORT_INDEX, idx);
        bus_access(siocfg_pkg::ACT_WRITE, siocfg_pkg::PORT_DATA, data);
    endtask

    task reg_read(logic [7:0] idx);
        bus_access(siocfg_pkg::ACT_WRITE, siocfg_pkg::PORT_INDEX, idx);
        bus_access(siocfg_pkg::ACT_READ, siocfg_pkg::PORT_DATA, 8'h00);
    endtask

    // stop offering and wait until every queued result has come back
    task drain_results();
        acc_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_q.size() != 0);
    endtask

    // register index biased toward the ones the serial ports use
    function automatic logic [7:0] pick_index();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range(0, siocfg_pkg::GLOBAL_LIMIT - 1));
            1:       return siocfg_pkg::REG_ACTIVATE;
            2:       return $urandom_range(0, 1) ? siocfg_pkg::REG_BASE_HI
                                                 : siocfg_pkg::REG_BASE_LO;
            3:       return siocfg_pkg::REG_IRQ;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // result side: random stall per transfer, calm stretches, one long hold-off
    initial begin : result_sink
        int      hold;
        t_result got;
        hold = 0;
        res_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_valid && res_ready) begin
                got.kind      = res_kind;
                got.read_byte = res_byte;
                got.unit      = res_unit;
                got.io_base   = res_base;
                got.irq       = res_irq;
                got.last      = res_last;
                sb.check_result(got);
                results_seen++;
                if (results_seen == 60)
                    hold = LONG_HOLD;   // sender keeps going, so the block backs up
                else if ((results_seen / 40) % 3 == 1)
                    hold = 0;
                else
                    hold = $urandom_range(0, 4);
            end else if (hold > 0) begin
                hold--;
            end
            res_ready <= (hold == 0);
        end
    end

    initial begin : access_source
        int  pick;
        bit  paused;
        sb = new();
        acc_valid  <= 1'b0;
        acc_action <= siocfg_pkg::ACT_WRITE;
        acc_port   <= siocfg_pkg::PORT_INDEX;
        acc_byte   <= 8'h00;
        rst_n      <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // index port read gives zero; data read at the reset index
        bus_access(siocfg_pkg::ACT_READ, siocfg_pkg::PORT_INDEX, 8'hFF);
        bus_access(siocfg_pkg::ACT_READ, siocfg_pkg::PORT_DATA, 8'h00);
        // config port base held in the global bank after reset
        reg_read(siocfg_pkg::REG_PORT_LO);

        // serial port 0 fully set up, port 1 only switched on; all outside config mode
        reg_write(siocfg_pkg::REG_DEV_SEL, siocfg_pkg::SERIAL0_DEV);
        reg_write(siocfg_pkg::REG_ACTIVATE, 8'h01);
        reg_write(siocfg_pkg::REG_BASE_HI, 8'hFF);
        reg_write(siocfg_pkg::REG_BASE_LO, 8'hF8);
        reg_write(siocfg_pkg::REG_IRQ, 8'hFF);
        reg_write(siocfg_pkg::REG_DEV_SEL, siocfg_pkg::SERIAL1_DEV);
        reg_write(siocfg_pkg::REG_ACTIVATE, 8'h80);

        // enter twice, then leave: both ports reported, unit 0 first
        bus_access(siocfg_pkg::ACT_WRITE, siocfg_pkg::PORT_INDEX, siocfg_pkg::KEY_ENTER);
        bus_access(siocfg_pkg::ACT_WRITE, siocfg_pkg::PORT_INDEX, siocfg_pkg::KEY_ENTER);
        bus_access(siocfg_pkg::ACT_WRITE, siocfg_pkg::PORT_INDEX, siocfg_pkg::KEY_LEAVE);
        // leave again while out of config mode: already active, nothing reported
        bus_access(siocfg_pkg::ACT_WRITE, siocfg_pkg::PORT_INDEX, siocfg_pkg::KEY_LEAVE);
        drain_results();

        // device number past the last bank: writes dropped, reads zero
        reg_write(siocfg_pkg::REG_DEV_SEL, 8'(NDEV));
        reg_write(siocfg_pkg::REG_ACTIVATE, 8'h5A);
        bus_access(siocfg_pkg::ACT_READ, siocfg_pkg::PORT_DATA, 8'h00);

        // random traffic, mostly select-then-access pairs with random content
        paused = 1'b0;
        while (items_sent < N_ITEMS) begin
            if (!paused && items_sent >= N_ITEMS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                reg_write(pick_index(), 8'($urandom_range(0, 255)));
            end else if (pick < 68) begin
                reg_read(pick_index());
            end else if (pick < 80) begin
                // mostly a real device, now and then one out of range
                reg_write(siocfg_pkg::REG_DEV_SEL, $urandom_range(0, 3) == 0 ?
                          8'($urandom_range(0, 255)) : 8'($urandom_range(0, NDEV - 1)));
            end else if (pick < 86) begin
                bus_access(siocfg_pkg::ACT_WRITE, siocfg_pkg::PORT_INDEX,
                           $urandom_range(0, 1) ? siocfg_pkg::KEY_ENTER
                                                : siocfg_pkg::KEY_LEAVE);
            end else if (pick < 89) begin
                bus_access(siocfg_pkg::ACT_READ, siocfg_pkg::PORT_INDEX,
                           8'($urandom_range(0, 255)));
            end else begin
                bus_access($urandom_range(0, 1) ? siocfg_pkg::ACT_READ
                                                : siocfg_pkg::ACT_WRITE,
                           $urandom_range(0, 1) ? siocfg_pkg::PORT_DATA
                                                : siocfg_pkg::PORT_INDEX,
                           8'($urandom_range(0, 255)));
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/siocfg_pkg.sv
hdl/siocfg_ctrl.sv
hdl/siocfg_dp.sv
hdl/superio_index_data_config_space_core.sv
sim/tb_superio_index_data_config_space_core.sv
